/* hdl/bblru_pkg.sv */
`default_nettype none

package bblru_pkg;

    // Command codes of a request.
    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_NONE   = 2'd3
    } command_t;

    // Budget limits in MiB and the shift from MiB to bytes.
    localparam logic [12:0] CAP_MIN_MB = 13'd1024;
    localparam logic [12:0] CAP_MAX_MB = 13'd4096;
    localparam int          MB_SHIFT   = 20;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
        logic [31:0] size_bytes;
    } request_t;

    typedef struct packed {
        logic        is_eviction;
        logic        hit;
        logic [31:0] evicted_key;
        logic [31:0] evicted_size;
        logic [32:0] used_bytes;
        logic [4:0]  entry_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic        last;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE,
        ST_PRE_RD,
        ST_PRE_EV,
        ST_CHECK,
        ST_EV_RD,
        ST_EV_APPLY,
        ST_EM_RD,
        ST_EM_OUT
    } state_t;

    // Clamp the budget register and convert it to bytes.
    function automatic logic [32:0] capacity_bytes(input logic [12:0] mb);
        logic [12:0] c;
        c = mb;
        if (mb < CAP_MIN_MB) c = CAP_MIN_MB;
        if (mb > CAP_MAX_MB) c = CAP_MAX_MB;
        return 33'(c) << MB_SHIFT;
    endfunction

endpackage

`default_nettype wire

/* hdl/bblru_ram.sv */
`default_nettype none

module bblru_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hdl/byte_budget_lru_tag_store.sv */
`default_nettype none

// Channel     | Ports                    | Transfer
// ------------+--------------------------+----------------------------------
// request     | start, busy, request     | edge with start high, busy low
// result      | done, result             | every cycle with done high
// config      | cfg_we, cfg_wdata        | edge with cfg_we high
//
// Keys and sizes live in one RAM with a registered read; valid
// bits and recency ranks are flip-flops. A lookup scans the RAM for the
// key, updates the recency ranks and then reads and builds the result. An
// insert adds a budget check, a read, an apply step and a further check per
// budget eviction, a read and a replace step for an eviction from a full
// table, and a read and an output step per further result. Clear and the
// unused command only build the result. The final result appears in the same cycle in which busy falls.
// Reset empties the table at once. Results cannot be stalled.

module byte_budget_lru_tag_store #(
    parameter int ENTRIES  = 16,
    parameter int KEY_BITS = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire bblru_pkg::request_t request,
    output logic                     done,
    output bblru_pkg::result_t       result,
    input  wire logic                cfg_we,
    input  wire logic [12:0]         cfg_wdata
);

    import bblru_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int EW = $clog2(ENTRIES + 2);
    localparam int DW = KEY_BITS + 32;

    state_t              state_reg, state_next;
    request_t            req_reg, req_next;
    logic [12:0]         cap_mb_reg;
    logic [ENTRIES-1:0]  valid_reg, valid_next;
    logic [IW-1:0]       rank_reg [ENTRIES];
    logic [IW-1:0]       rank_next [ENTRIES];
    logic [CW-1:0]       count_reg, count_next;
    logic [32:0]         bytes_reg, bytes_next;
    logic [31:0]         hits_reg, hits_next;
    logic [31:0]         misses_reg, misses_next;
    logic [CW-1:0]       scan_reg, scan_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]       cmp_idx_reg, cmp_idx_next;
    logic                found_reg, found_next;
    logic [IW-1:0]       match_reg, match_next;
    logic [31:0]         msize_reg, msize_next;
    logic                hit_reg, hit_next;
    logic [IW-1:0]       vict_reg, vict_next;
    logic                pre_reg, pre_next;
    logic [KEY_BITS-1:0] pre_key_reg, pre_key_next;
    logic [31:0]         pre_size_reg, pre_size_next;
    logic [IW-1:0]       evq_reg [ENTRIES];
    logic [IW-1:0]       evq_next [ENTRIES];
    logic [CW-1:0]       qcnt_reg, qcnt_next;
    logic [EW-1:0]       em_reg, em_next;
    logic                done_reg, done_next;
    result_t             res_reg, res_next;

    logic                ram_we;
    logic [IW-1:0]       ram_waddr, ram_raddr;
    logic [DW-1:0]       ram_wdata, ram_rdata;
    logic [KEY_BITS-1:0] rd_key, key_in;
    logic [31:0]         rd_size;
    logic [IW-1:0]       victim, free_slot;
    logic [32:0]         cap_bytes;
    logic [EW-1:0]       total;
    logic [IW-1:0]       qidx;

    bblru_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_key    = ram_rdata[DW-1:32];
    assign rd_size   = ram_rdata[31:0];
    assign key_in    = KEY_BITS'(req_reg.key);
    assign cap_bytes = capacity_bytes(cap_mb_reg);
    assign total     = EW'(pre_reg) + EW'(qcnt_reg);
    assign qidx      = IW'(em_reg - EW'(pre_reg));
    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign result    = res_reg;

    // Least recent valid entry and lowest free slot.
    always_comb
    begin
        victim    = '0;
        free_slot = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && rank_reg[i] == '0)
            begin
                victim = IW'(i);
            end
            if (!valid_reg[i])
            begin
                free_slot = IW'(i);
            end
        end
    end

    // Next state, datapath updates and RAM accesses.
    always_comb
    begin
        state_next    = state_reg;
        req_next      = req_reg;
        valid_next    = valid_reg;
        rank_next     = rank_reg;
        count_next    = count_reg;
        bytes_next    = bytes_reg;
        hits_next     = hits_reg;
        misses_next   = misses_reg;
        scan_next     = scan_reg;
        cmp_vld_next  = cmp_vld_reg;
        cmp_idx_next  = cmp_idx_reg;
        found_next    = found_reg;
        match_next    = match_reg;
        msize_next    = msize_reg;
        hit_next      = hit_reg;
        vict_next     = vict_reg;
        pre_next      = pre_reg;
        pre_key_next  = pre_key_reg;
        pre_size_next = pre_size_reg;
        evq_next      = evq_reg;
        qcnt_next     = qcnt_reg;
        em_next       = em_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = {key_in, req_reg.size_bytes};
        ram_raddr     = victim;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_next  = request;
                    hit_next  = 1'b0;
                    pre_next  = 1'b0;
                    qcnt_next = '0;
                    em_next   = '0;
                    case (request.command)
                        CMD_LOOKUP, CMD_INSERT:
                        begin
                            scan_next    = '0;
                            cmp_vld_next = 1'b0;
                            found_next   = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        CMD_CLEAR:
                        begin
                            valid_next  = '0;
                            for (int i = 0; i < ENTRIES; i++)
                            begin
                                rank_next[i] = '0;
                            end
                            count_next  = '0;
                            bytes_next  = '0;
                            hits_next   = '0;
                            misses_next = '0;
                            state_next  = ST_EM_RD;
                        end
                        default:
                        begin
                            state_next = ST_EM_RD;
                        end
                    endcase
                end
            end

            // Stream the RAM and compare each returned key.
            ST_SCAN:
            begin
                ram_raddr = scan_reg[IW-1:0];
                if (cmp_vld_reg && valid_reg[cmp_idx_reg] && rd_key == key_in)
                begin
                    found_next = 1'b1;
                    match_next = cmp_idx_reg;
                    msize_next = rd_size;
                end
                cmp_vld_next = (scan_reg < CW'(ENTRIES));
                cmp_idx_next = scan_reg[IW-1:0];
                scan_next    = scan_reg + 1'b1;
                if (scan_reg == CW'(ENTRIES))
                begin
                    state_next = ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                hit_next = found_reg;
                if (found_reg)
                begin
                    // Move the matched entry to most recent.
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (valid_reg[i] && IW'(i) != match_reg
                            && rank_reg[i] > rank_reg[match_reg])
                        begin
                            rank_next[i] = rank_reg[i] - 1'b1;
                        end
                    end
                    rank_next[match_reg] = IW'(count_reg - 1'b1);
                end
                if (req_reg.command == CMD_LOOKUP)
                begin
                    if (found_reg && hits_reg != '1)
                    begin
                        hits_next = hits_reg + 1'b1;
                    end
                    if (!found_reg && misses_reg != '1)
                    begin
                        misses_next = misses_reg + 1'b1;
                    end
                    state_next = ST_EM_RD;
                end
                else if (found_reg)
                begin
                    bytes_next = bytes_reg - 33'(msize_reg) + 33'(req_reg.size_bytes);
                    ram_we     = 1'b1;
                    ram_waddr  = match_reg;
                    state_next = ST_CHECK;
                end
                else if (count_reg == CW'(ENTRIES))
                begin
                    state_next = ST_PRE_RD;
                end
                else
                begin
                    valid_next[free_slot] = 1'b1;
                    rank_next[free_slot]  = IW'(count_reg);
                    count_next = count_reg + 1'b1;
                    bytes_next = bytes_reg + 33'(req_reg.size_bytes);
                    ram_we     = 1'b1;
                    ram_waddr  = free_slot;
                    state_next = ST_CHECK;
                end
            end

            ST_PRE_RD:
            begin
                vict_next  = victim;
                state_next = ST_PRE_EV;
            end

            // Full table: the victim slot takes the new key as most recent.
            ST_PRE_EV:
            begin
                pre_next      = 1'b1;
                pre_key_next  = rd_key;
                pre_size_next = rd_size;
                bytes_next    = bytes_reg - 33'(rd_size) + 33'(req_reg.size_bytes);
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] != '0)
                    begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                rank_next[vict_reg] = IW'(ENTRIES - 1);
                ram_we     = 1'b1;
                ram_waddr  = vict_reg;
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (bytes_reg > cap_bytes && count_reg != '0)
                begin
                    state_next = ST_EV_RD;
                end
                else
                begin
                    state_next = ST_EM_RD;
                end
            end

            ST_EV_RD:
            begin
                vict_next  = victim;
                state_next = ST_EV_APPLY;
            end

            // Drop the least recent entry and queue it for reporting.
            ST_EV_APPLY:
            begin
                bytes_next = bytes_reg - 33'(rd_size);
                valid_next[vict_reg] = 1'b0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] != '0)
                    begin
                        rank_next[i] = rank_reg[i] - 1'b1;
                    end
                end
                rank_next[vict_reg]          = '0;
                count_next                   = count_reg - 1'b1;
                evq_next[qcnt_reg[IW-1:0]]   = vict_reg;
                qcnt_next                    = qcnt_reg + 1'b1;
                state_next                   = ST_CHECK;
            end

            ST_EM_RD:
            begin
                ram_raddr  = evq_reg[qidx];
                state_next = ST_EM_OUT;
            end

            // Build one result from the queued eviction or the step summary.
            ST_EM_OUT:
            begin
                res_next.is_eviction  = (total != '0);
                res_next.hit          = hit_reg;
                res_next.evicted_key  = '0;
                res_next.evicted_size = '0;
                if (total != '0)
                begin
                    if (pre_reg && em_reg == '0)
                    begin
                        res_next.evicted_key  = 32'(pre_key_reg);
                        res_next.evicted_size = pre_size_reg;
                    end
                    else
                    begin
                        res_next.evicted_key  = 32'(rd_key);
                        res_next.evicted_size = rd_size;
                    end
                end
                res_next.used_bytes  = bytes_reg;
                res_next.entry_count = 5'(count_reg);
                res_next.hit_total   = hits_reg;
                res_next.miss_total  = misses_reg;
                res_next.last        = (total == '0) || (em_reg == total - 1'b1);
                done_next            = 1'b1;
                if (res_next.last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    em_next    = em_reg + 1'b1;
                    state_next = ST_EM_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cap_mb_reg <= CAP_MIN_MB;
            valid_reg  <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
            count_reg  <= '0;
            bytes_reg  <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cap_mb_reg <= cfg_wdata;
            end
            valid_reg  <= valid_next;
            rank_reg   <= rank_next;
            count_reg  <= count_next;
            bytes_reg  <= bytes_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            done_reg   <= done_next;
        end
    end

    // Working registers of one step.
    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        scan_reg     <= scan_next;
        cmp_vld_reg  <= cmp_vld_next;
        cmp_idx_reg  <= cmp_idx_next;
        found_reg    <= found_next;
        match_reg    <= match_next;
        msize_reg    <= msize_next;
        hit_reg      <= hit_next;
        vict_reg     <= vict_next;
        pre_reg      <= pre_next;
        pre_key_reg  <= pre_key_next;
        pre_size_reg <= pre_size_next;
        evq_reg      <= evq_next;
        qcnt_reg     <= qcnt_next;
        em_reg       <= em_next;
        res_reg      <= res_next;
    end

    // The entry count tracks the valid bits.
    a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == CW'($countones(valid_reg)))
        else $error("entry count differs from valid bits");

    // A result transfer only follows the output step.
    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) == ST_EM_OUT)
        else $error("result strobe without output step");

    // The RAM is never written while the block is idle.
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("RAM write while idle");

    // An eviction is only taken when the budget is exceeded.
    a_evict_reason: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EV_RD |-> $past(bytes_reg > cap_bytes))
        else $error("eviction within budget");

endmodule

`default_nettype wire

/* test/lru_store_checker.sv */
`default_nettype none

module lru_store_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic                busy,
    input  wire bblru_pkg::request_t request,
    input  wire logic                done,
    input  wire bblru_pkg::result_t  result,
    input  wire logic                cfg_we,
    input  wire logic [12:0]         cfg_wdata,
    output int                       fail_count,
    output int                       pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    import bblru_pkg::*;

    localparam int SLOTS = 16;

    // Shadow copy of the tag store.
    logic [31:0] slot_key   [SLOTS];
    logic [31:0] slot_size  [SLOTS];
    logic        slot_valid [SLOTS];
    logic [3:0]  slot_rank  [SLOTS];
    logic [32:0] bytes_held;
    logic [31:0] hit_count;
    logic [31:0] miss_count;
    logic [12:0] budget_mb;

    result_t expected_results[$];
    logic [31:0] gone_key  [$];
    logic [31:0] gone_size [$];

    assign pending_results = expected_results.size();

    function automatic int live_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i]) n++;
        return n;
    endfunction

    function automatic int slot_of(logic [31:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && slot_key[i] == k) return i;
        return -1;
    endfunction

    function automatic logic [32:0] budget_bytes();
        logic [12:0] mb;
        mb = budget_mb;
        if (mb < 13'd1024) mb = 13'd1024;
        if (mb > 13'd4096) mb = 13'd4096;
        return {mb, 20'd0};
    endfunction

    task automatic promote(int s);
        logic [3:0] r;
        r = slot_rank[s];
        for (int i = 0; i < SLOTS; i++)
            if (slot_valid[i] && i != s && slot_rank[i] > r) slot_rank[i]--;
        slot_rank[s] = 4'(live_count() - 1);
    endtask

    task automatic drop_oldest();
        int victim;
        victim = -1;
        for (int i = 0; i < SLOTS; i++)
            if (victim < 0 && slot_valid[i] && slot_rank[i] == 0) victim = i;
        if (victim >= 0)
        begin
            slot_valid[victim] = 1'b0;
            bytes_held -= 33'(slot_size[victim]);
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_rank[i] > 0) slot_rank[i]--;
            slot_rank[victim] = 0;
            gone_key = {gone_key, slot_key[victim]};
            gone_size = {gone_size, slot_size[victim]};
        end
    endtask

    // Apply one request to the shadow store and queue its results.
    task automatic predict_request(request_t req);
        logic found;
        int s;
        int n;
        result_t r;
        found = 1'b0;
        gone_key.delete();
        gone_size.delete();
        case (command_t'(req.command))
            CMD_LOOKUP:
            begin
                s = slot_of(req.key);
                if (s >= 0)
                begin
                    found = 1'b1;
                    if (hit_count != '1) hit_count++;
                    promote(s);
                end
                else if (miss_count != '1) miss_count++;
            end
            CMD_INSERT:
            begin
                s = slot_of(req.key);
                found = (s >= 0);
                if (found)
                begin
                    bytes_held -= 33'(slot_size[s]);
                    promote(s);
                end
                else
                begin
                    if (live_count() >= SLOTS) drop_oldest();
                    for (int i = SLOTS - 1; i >= 0; i--)
                        if (!slot_valid[i]) s = i;
                    slot_rank[s] = 4'(live_count());
                    slot_valid[s] = 1'b1;
                    slot_key[s] = req.key;
                end
                slot_size[s] = req.size_bytes;
                bytes_held += 33'(req.size_bytes);
                while (bytes_held > budget_bytes() && live_count() > 0) drop_oldest();
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    slot_valid[i] = 1'b0;
                    slot_rank[i] = 0;
                end
                bytes_held = 0;
                hit_count = 0;
                miss_count = 0;
            end
            default: ;
        endcase
        n = (gone_key.size() > 0) ? gone_key.size() : 1;
        for (int i = 0; i < n; i++)
        begin
            r = '0;
            r.is_eviction = (i < gone_key.size());
            r.hit = found;
            if (r.is_eviction)
            begin
                r.evicted_key = gone_key[i];
                r.evicted_size = gone_size[i];
            end
            r.used_bytes = bytes_held;
            r.entry_count = 5'(live_count());
            r.hit_total = hit_count;
            r.miss_total = miss_count;
            r.last = (i == n - 1);
            expected_results = {expected_results, r};
        end
    endtask

    // Watch config writes, request transfers and result transfers.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_rank[i] = 0;
            end
            bytes_held = 0;
            hit_count = 0;
            miss_count = 0;
            budget_mb = 13'd1024;
            fail_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    if (result !== expected_results[0])
                    begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, expected_results[0], result);
                        fail_count++;
                    end
                    void'(expected_results.pop_front());
                end
            end
            if (cfg_we) budget_mb = cfg_wdata;
            if (start && !busy) predict_request(request);
        end
    end
endmodule

`default_nettype wire

/* test/tb_byte_budget_lru_tag_store.sv */
`default_nettype none

module tb_byte_budget_lru_tag_store;
    timeunit 1ns;
    timeprecision 1ps;

    import bblru_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;
    logic     cfg_we;
    logic [12:0] cfg_wdata;
    int       fail_count;
    int       pending_results;
    int       cycle_count = 0;

    // Small key pool so that hits, replacements and evictions are common.
    logic [31:0] key_pool[8];

    byte_budget_lru_tag_store DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    lru_store_checker checker_inst (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_results(pending_results)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** byte_budget_lru_tag_store: FAILED **");
            $finish;
        end
    end

    // Drive one request at a falling edge and hold it until its transfer.
    task automatic send_request(command_t c, logic [31:0] k, logic [31:0] sz);
        request = '{command: c, key: k, size_bytes: sz};
        start = 1'b1;
        while (busy) @(negedge clk);
        @(negedge clk);
        start = 1'b0;
    endtask

    // Wait for all outstanding results, then idle for a while.
    task automatic drain();
        while (pending_results != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic write_budget(logic [12:0] mb);
        drain();
        cfg_we = 1'b1;
        cfg_wdata = mb;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] random_size();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return 0;
            default: return $urandom_range(0, 32'h4000_0000);
        endcase
    endfunction

    task automatic random_phase(int count, bit quiet);
        command_t c;
        logic [31:0] k;
        for (int i = 0; i < count; i++)
        begin
            if (!quiet && $urandom_range(0, 99) < 9)
                repeat ($urandom_range(1, 6)) @(negedge clk);
            case ($urandom_range(0, 19))
                0: c = CMD_CLEAR;
                1: c = CMD_NONE;
                2, 3, 4, 5, 6, 7, 8: c = CMD_LOOKUP;
                default: c = CMD_INSERT;
            endcase
            k = ($urandom_range(0, 3) == 0) ? $urandom() : key_pool[$urandom_range(0, 7)];
            send_request(c, k, random_size());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_we = 1'b0;
        cfg_wdata = 13'd1024;
        for (int i = 0; i < 8; i++) key_pool[i] = $urandom();
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, every command, over-budget and full-table cases.
        send_request(CMD_LOOKUP, 32'h0, 32'h0);
        send_request(CMD_INSERT, 32'h0, 32'h0);
        send_request(CMD_LOOKUP, 32'h0, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'h1, 32'h3000_0000);
        send_request(CMD_INSERT, 32'h2, 32'h2000_0000);
        send_request(CMD_INSERT, 32'h1, 32'h0000_0010);
        send_request(CMD_NONE, 32'h1, 32'h5);
        for (int i = 0; i < 17; i++)
            send_request(CMD_INSERT, 32'h100 + i, 32'h1000);
        send_request(CMD_LOOKUP, 32'h101, 32'h0);
        write_budget(13'd4096);
        send_request(CMD_INSERT, 32'h3, 32'hFFFF_FFFF);
        write_budget(13'd0);
        send_request(CMD_LOOKUP, 32'h3, 32'h0);
        send_request(CMD_INSERT, 32'h4, 32'h1);
        send_request(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Random phases across budget settings, one of them without gaps.
        write_budget(13'h1FFF);
        random_phase(60, 1'b0);
        write_budget(13'd2500);
        random_phase(60, 1'b1);
        write_budget(13'd1024);
        random_phase(55, 1'b0);
        write_budget(13'd4096);
        random_phase(55, 1'b0);

        drain();
        if (fail_count == 0)
            $display("** byte_budget_lru_tag_store: PASSED **");
        else
            $display("** byte_budget_lru_tag_store: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire

/* sim.f */
hdl/bblru_pkg.sv
hdl/bblru_ram.sv
hdl/byte_budget_lru_tag_store.sv
test/lru_store_checker.sv
test/tb_byte_budget_lru_tag_store.sv
